/* rtl/laplacian_sharpen_3x3_assert.svh */
// Assertion macros for the Laplacian sharpening block.
// Needs clk_i and rst_ni in the scope that uses the macros.
`ifndef LAPLACIAN_SHARPEN_3X3_ASSERT_SVH
`define LAPLACIAN_SHARPEN_3X3_ASSERT_SVH
`ifndef SYNTHESIS
`define LSH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LSH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSH_ASSERT_IMP(label, ante, cons, msg)
`define LSH_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* rtl/lsh_pkg.sv */
// Shared types, constants and the per-channel sharpening function.
// No dependencies.
package lsh_pkg;

  localparam int MaxWidth = 2048;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int WidthW   = 12;
  localparam int HeightW  = 16;
  localparam int RowW     = HeightW + 1;
  localparam int RCmpW    = RowW + 1;
  localparam int CmpW     = ((ColW > WidthW) ? ColW : WidthW) + 1;
  localparam int PixW     = 24;
  localparam int PaddrW   = 4;
  localparam int CfgDataW = 32;

  typedef logic [PixW-1:0] pixel_t;
  typedef logic [7:0]      byte_t;

  typedef enum logic [1:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1,
    RegColorMode   = 2'd2
  } cfg_reg_e;

  // 5*centre - up - down - left - right, clamped to 0..255
  function automatic byte_t sharpen(byte_t c, byte_t u, byte_t d, byte_t l, byte_t r);
    logic signed [11:0] v;
    byte_t              res;
    v = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
        - $signed({4'b0000, u}) - $signed({4'b0000, d})
        - $signed({4'b0000, l}) - $signed({4'b0000, r});
    if (v[11]) begin
      res = 8'h00;
    end else if (v[10:8] != 3'b000) begin
      res = 8'hFF;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

/* rtl/laplacian_sharpen_3x3.sv */
// Laplacian 3x3 cross-kernel sharpening of a raster pixel stream.
// Depends on lsh_pkg, lsh_line_buf and laplacian_sharpen_3x3_assert.svh.
//
// Usage:
//   Input stream: one pixel per request, raster order. tdata holds the three
//   channel bytes, tuser marks a drain request (no data, pushes the tail out).
//   Output stream: one sharpened pixel per frame pixel, tlast on the frame's last.
//   Interior pixels become, per channel, 5*centre minus the up, down, left
//   and right neighbors, clamped to 0..255; border pixels pass unchanged.
//   Grey mode uses channel 0 only and drives channels 1 and 2 as zero.
//   The result for pixel (row, col) is caused by the input request W+1
//   positions later (one row and one pixel); send W+1 drain requests after a
//   frame to flush it. The accepted request is held in stage 1; its result
//   loads the output register once stage 1 frees.
//   Throughput: one request per cycle while the output side does not stall;
//   each row buffer takes one read and one write per cycle. A request that
//   causes no result never waits for the output register.
//   Reset clears counters and window, loads 640x480 grey; row buffers hold no
//   defined data until written. While the receiver stalls, the held result
//   stays in the output register; stage 1 takes requests until one holds a result.
//   Any write to a mapped register restarts the frame at row 0, column 0.
`include "laplacian_sharpen_3x3_assert.svh"

module laplacian_sharpen_3x3 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // APB configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsh_pkg::PaddrW-1:0] paddr,
  input  logic [lsh_pkg::CfgDataW-1:0] pwdata,
  output logic [lsh_pkg::CfgDataW-1:0] prdata,
  output logic                      pready,
  // input stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [23:0]               s_axis_tdata_i,  // chan_a, chan_b, chan_c
  input  logic                      s_axis_tuser_i,  // operation
  // output stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [23:0]               m_axis_tdata_o,  // out_a, out_b, out_c
  output logic                      m_axis_tlast_o   // frame_end
);
  import lsh_pkg::*;

  // configuration registers
  logic [WidthW-1:0]  frame_width_q;
  logic [HeightW-1:0] frame_height_q;
  logic               color_mode_q;
  logic               cfg_wr;
  logic               cfg_restart;
  cfg_reg_e           cfg_idx;

  // input position
  logic [ColW-1:0] in_col_q, in_col_d;
  logic [RowW-1:0] in_row_q, in_row_d;

  // stage 1 (after the row buffer read)
  logic   s1_vld_q, s1_emit_q, s1_last_q, s1_int_q, s1_cmode_q;
  pixel_t s1_x_q;

  // neighborhood window
  pixel_t win_up_q, win_dn_q, win_lf_q, centre_q;

  // output register
  logic   out_vld_q, out_last_q;
  pixel_t out_pix_q;

  // stage 0 decode
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic [ColW-1:0]    prev_col;
  logic [RowW-1:0]    orow;
  logic               emit, interior, last, col_wrap, data_ok;
  pixel_t             x_in;

  logic   accept, s1_go;
  pixel_t buf_up, buf_right, sharp, res;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      RegFrameWidth:  prdata = CfgDataW'(frame_width_q);
      RegFrameHeight: prdata = CfgDataW'(frame_height_q);
      RegColorMode:   prdata = CfgDataW'(color_mode_q);
      default:        prdata = '0;
    endcase
  end

  // only a write that lands on a register restarts the frame
  always_comb begin
    case (cfg_idx)
      RegFrameWidth, RegFrameHeight, RegColorMode: cfg_restart = cfg_wr;
      default:                                     cfg_restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthW'(640);
      frame_height_q <= HeightW'(480);
      color_mode_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegFrameWidth:  frame_width_q  <= pwdata[WidthW-1:0];
        RegFrameHeight: frame_height_q <= pwdata[HeightW-1:0];
        RegColorMode:   color_mode_q   <= pwdata[0];
        default:        ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: position decode of the incoming request
  // ---------------------------------------------------------------------
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (CmpW'(frame_width_q) > CmpW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = frame_width_q;
    end
  end

  assign h_eff = (frame_height_q == '0) ? HeightW'(1) : frame_height_q;

  // column of the centre pixel, one left of the input, wrapping to the row's end
  assign prev_col = (in_col_q == '0) ? ColW'(w_eff - WidthW'(1)) : in_col_q - ColW'(1);

  assign emit = (in_row_q >= RowW'(2)) || ((in_row_q == RowW'(1)) && (in_col_q != '0));
  assign orow = (in_col_q == '0) ? in_row_q - RowW'(2) : in_row_q - RowW'(1);

  assign interior = (orow >= RowW'(1))
                 && (RCmpW'(orow) + RCmpW'(1) < RCmpW'(h_eff))
                 && (prev_col != '0)
                 && (CmpW'(prev_col) + CmpW'(1) < CmpW'(w_eff));

  // the last result comes with column 0 of the second row after the frame
  assign last = emit && (in_col_q == '0) && (in_row_q == RowW'(h_eff) + RowW'(1));

  assign col_wrap = (CmpW'(in_col_q) + CmpW'(1) >= CmpW'(w_eff));

  // drain requests and pixels past the frame count as zero pixels
  assign data_ok = !s_axis_tuser_i && (in_row_q < RowW'(h_eff));
  assign x_in    = !data_ok      ? '0 :
                   color_mode_q ? s_axis_tdata_i :
                                  {16'h0000, s_axis_tdata_i[7:0]};

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (accept) begin
      if (last) begin
        in_col_d = '0;
        in_row_d = '0;
      end else if (col_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + RowW'(1);
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
    end
    if (cfg_restart) begin
      in_col_d = '0;
      in_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
    end
  end

  // ---------------------------------------------------------------------
  // handshake: stage 1 frees when its item needs no output slot or the
  // output register can take it
  // ---------------------------------------------------------------------
  assign s1_go           = s1_vld_q && (!s1_emit_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || s1_go;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  lsh_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .addr_i    (in_col_q),
    .wr_data_i (x_in),
    .up_o      (buf_up),
    .right_o   (buf_right)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (s1_go) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q  <= emit;
      s1_last_q  <= last;
      s1_int_q   <= interior;
      s1_cmode_q <= color_mode_q;
      s1_x_q     <= x_in;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: sharpen each channel; centre is the previous step's right
  // ---------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sharp[8*k +: 8] = sharpen(centre_q[8*k +: 8], win_up_q[8*k +: 8],
                                win_dn_q[8*k +: 8], win_lf_q[8*k +: 8],
                                buf_right[8*k +: 8]);
    end
  end

  always_comb begin
    res = s1_int_q ? sharp : centre_q;
    if (!s1_cmode_q) begin
      res[23:8] = 16'h0000;
    end
  end

  // advance the window once the item leaves stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_up_q <= '0;
      win_dn_q <= '0;
      win_lf_q <= '0;
      centre_q <= '0;
    end else if (s1_go) begin
      win_up_q <= buf_up;
      win_dn_q <= s1_x_q;
      win_lf_q <= centre_q;
      centre_q <= buf_right;
    end
  end

  // ---------------------------------------------------------------------
  // output register: hold while the receiver stalls
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_go && s1_emit_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emit_q) begin
      out_pix_q  <= res;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `LSH_ASSERT_IMP(a_col_range, 1'b1, CmpW'(in_col_q) < CmpW'(w_eff), "column past row end")
  `LSH_ASSERT_IMP(a_row_range, 1'b1, RCmpW'(in_row_q) <= RCmpW'(h_eff) + RCmpW'(1), "row past frame")
  `LSH_ASSERT_IMP(a_last_emits, s1_vld_q && s1_last_q, s1_emit_q, "frame end without result")
  `LSH_ASSERT_NXT(a_last_restart, accept && last, (in_row_q == '0) && (in_col_q == '0), "no restart")

endmodule

/* rtl/lsh_line_buf.sv */
// Two row buffers: the newer row takes the incoming pixel, the older row
// takes what the newer row held at that column. Depends on lsh_pkg.
module lsh_line_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [lsh_pkg::ColW-1:0] addr_i,
  input  lsh_pkg::pixel_t        wr_data_i,
  output lsh_pkg::pixel_t        up_o,
  output lsh_pkg::pixel_t        right_o
);
  import lsh_pkg::*;

  pixel_t newer_mem [MaxWidth];
  pixel_t older_mem [MaxWidth];

  pixel_t            right_q;
  pixel_t            up_q;
  logic              wr_pend_q;
  logic [ColW-1:0]   wr_addr_q;

  // newer row: read old contents, write the new pixel at the same column
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      right_q          <= newer_mem[addr_i];
      newer_mem[addr_i] <= wr_data_i;
    end
  end

  // older row: written in the cycle after the read, with the newer row's data
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      older_mem[wr_addr_q] <= right_q;
    end
    if (rd_en_i) begin
      if (wr_pend_q && (wr_addr_q == addr_i)) begin
        up_q <= right_q;
      end else begin
        up_q <= older_mem[addr_i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
      wr_addr_q <= '0;
    end else begin
      wr_pend_q <= rd_en_i;
      if (rd_en_i) begin
        wr_addr_q <= addr_i;
      end
    end
  end

  assign up_o    = up_q;
  assign right_o = right_q;

endmodule

/* sim/laplacian_sharpen_3x3_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for laplacian_sharpen_3x3: a line-buffer model predicts every
// sharpened pixel and a scoreboard compares it with the output stream.
// Depends on lsh_pkg and the laplacian_sharpen_3x3 RTL only.

module laplacian_sharpen_3x3_tb;

  localparam int          ClkHalf     = 4;
  localparam int          CentreGain  = 5;
  localparam int          MaxReports  = 10;
  localparam int          SettleIdle  = 8;       // result register loads from stage 1, after accept
  localparam int          LongHold    = 400;
  localparam int          BulkItems   = 1200;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam logic [1:0]  RegUnmapped = 2'd3;    // first index past the register list

  // Line-buffer model of the block plus the queue of pixels it still owes.
  class sharpen_scoreboard;
    typedef struct {
      bit [7:0] a;
      bit [7:0] b;
      bit [7:0] c;
      bit       last;
    } sharp_px_t;

    bit [23:0]   older_row [lsh_pkg::MaxWidth];
    bit [23:0]   newer_row [lsh_pkg::MaxWidth];
    bit [23:0]   nb_up, nb_down, nb_left;
    int unsigned col, row, out_count;
    bit [11:0]   width_reg  = 12'd640;
    bit [15:0]   height_reg = 16'd480;
    bit          color_reg  = 1'b0;
    sharp_px_t   owed_pixels[$];
    int unsigned mismatches;

    function void restart();
      col       = 0;
      row       = 0;
      out_count = 0;
    endfunction

    // Any mapped write restarts the frame; line buffers and window keep their data.
    function void apply_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        lsh_pkg::RegFrameWidth:  width_reg  = value[11:0];
        lsh_pkg::RegFrameHeight: height_reg = value[15:0];
        lsh_pkg::RegColorMode:   color_reg  = value[0];
        default: return;
      endcase
      restart();
    endfunction

    function bit [7:0] cross_clamp(bit [7:0] ctr, bit [7:0] up, bit [7:0] dn,
                                   bit [7:0] lf, bit [7:0] rt);
      int v;
      v = CentreGain * int'(ctr) - int'(up) - int'(dn) - int'(lf) - int'(rt);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    // Advance the model by one accepted request; queue the pixel it releases, if any.
    function void accept_pixel(bit drain, bit [23:0] data);
      int unsigned w, h, total, c, prev, orow;
      bit [23:0]   x, centre, right, saved_up, res;
      bit          last;
      last  = 1'b0;
      w     = (width_reg == 0) ? 1 : ((width_reg > lsh_pkg::MaxWidth) ? lsh_pkg::MaxWidth
                                                                       : width_reg);
      h     = (height_reg == 0) ? 1 : height_reg;
      total = w * h;
      c     = col;
      prev  = (c == 0) ? w - 1 : c - 1;
      if (c >= w) c = 0;
      // drains and pixels past the frame's end enter as all-zero pixels
      x = '0;
      if (!drain && row < h) x = color_reg ? data : {16'h0, data[7:0]};
      centre   = older_row[prev];
      right    = newer_row[c];
      saved_up = older_row[c];
      if (row >= 2 || (row == 1 && c >= 1)) begin
        orow = (c == 0) ? row - 2 : row - 1;
        res  = centre;
        last = (out_count == total - 1);
        // border pixels pass unchanged, interior ones take the cross kernel
        if (orow >= 1 && orow + 1 < h && prev >= 1 && prev + 1 < w) begin
          for (int k = 0; k < 3; k++) begin
            res[8*k +: 8] = cross_clamp(centre[8*k +: 8], nb_up[8*k +: 8],
                                        nb_down[8*k +: 8], nb_left[8*k +: 8],
                                        right[8*k +: 8]);
          end
        end
        if (!color_reg) res[23:8] = '0;
        owed_pixels.push_back('{res[7:0], res[15:8], res[23:16], last});
        out_count++;
      end
      nb_up        = saved_up;
      nb_down      = x;
      nb_left      = centre;
      older_row[c] = right;
      newer_row[c] = x;
      if (last) begin
        restart();
      end else if (c + 1 >= w) begin
        col = 0;
        row++;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_pixel(bit [23:0] data, bit last_flag);
      sharp_px_t want;
      if (owed_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected pixel a=%0d b=%0d c=%0d end=%0b",
                   data[7:0], data[15:8], data[23:16], last_flag);
        return;
      end
      want = owed_pixels.pop_front();
      if (want.a != data[7:0] || want.b != data[15:8] || want.c != data[23:16] ||
          want.last != last_flag) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("pixel mismatch: expected a=%0d b=%0d c=%0d end=%0b,",
                   want.a, want.b, want.c, want.last,
                   " got a=%0d b=%0d c=%0d end=%0b",
                   data[7:0], data[15:8], data[23:16], last_flag);
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_ni          = 1'b0;
  logic                         psel            = 1'b0;
  logic                         penable         = 1'b0;
  logic                         pwrite          = 1'b0;
  logic [lsh_pkg::PaddrW-1:0]   paddr           = '0;
  logic [lsh_pkg::CfgDataW-1:0] pwdata          = '0;
  logic [lsh_pkg::CfgDataW-1:0] prdata;
  logic                         pready;
  logic                         s_axis_tvalid   = 1'b0;
  logic                         s_axis_tready;
  logic [23:0]                  s_axis_tdata    = '0;  // chan_a, chan_b, chan_c
  logic                         s_axis_tuser    = 1'b0; // operation
  logic                         m_axis_tvalid;
  logic                         m_axis_tready   = 1'b0;
  logic [23:0]                  m_axis_tdata;          // out_a, out_b, out_c
  logic                         m_axis_tlast;          // frame_end

  sharpen_scoreboard board;
  int unsigned       sent;          // requests accepted so far
  int unsigned       bulk_base;     // value of sent when the random part starts
  bit                in_bulk;
  bit                steady;        // no idling on either side while set
  int unsigned       hold_asked;
  int unsigned       hold_taken;
  int unsigned       cycles;

  laplacian_sharpen_3x3 i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  // Offer one request and hold it until accepted. Valid stays high on return so that
  // back-to-back requests never drop it; an idle gap drops it first.
  task automatic push_item(bit drain, bit [23:0] data);
    if (in_bulk) begin
      steady = (sent >= bulk_base + 300) && (sent < bulk_base + 650);
      // starve the output side here so the block fills and stalls its input
      if (sent == bulk_base + 900) hold_asked++;
    end
    if (!steady && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= drain;
    do @(posedge clk); while (!s_axis_tready);
    board.accept_pixel(drain, data);
    sent++;
  endtask

  // Drop the request line and wait until every owed pixel is out and the pipe is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.owed_pixels.size() != 0) @(posedge clk);
    repeat (SettleIdle) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.apply_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, bit color);
    apb_write(lsh_pkg::RegFrameWidth, w);
    apb_write(lsh_pkg::RegFrameHeight, h);
    apb_write(lsh_pkg::RegColorMode, {31'd0, color});
  endtask

  // Send a frame of random pixels plus its W+1 flush requests; cut > 0 truncates it.
  // Body pixels are drains now and then, flush requests are data or drain at random.
  task automatic send_frame(int unsigned w, int unsigned h, int unsigned cut);
    int unsigned n;
    n = (cut != 0) ? cut : w * h + w + 1;
    for (int unsigned i = 0; i < n; i++) begin
      if (i < w * h) push_item($urandom_range(9) == 0, 24'($urandom));
      else push_item(1'($urandom_range(1)), 24'($urandom));
    end
  endtask

  // 3x3 frame whose only interior pixel is the centre, then its four flush requests.
  task automatic send_cross_frame(bit [23:0] ring, bit [23:0] centre, bit data_tail);
    for (int i = 0; i < 9; i++) push_item(1'b0, (i == 4) ? centre : ring);
    repeat (4) push_item(!data_tail, data_tail ? 24'($urandom) : 24'd0);
  endtask

  // Output side: check each accepted pixel, then pick the next ready level.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) board.check_pixel(m_axis_tdata, m_axis_tlast);
      if (hold_asked != hold_taken) begin
        hold_taken = hold_asked;
        hold_left  = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles == CycleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase, w, h, frames;
    board = new();
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed: every saturation edge and the exact-255 case on the one interior pixel.
    // First frame flushes with drains, the second with surplus data pixels that must
    // behave as drains, and it also starts right after the first frame's end.
    set_frame(3, 3, 1'b1);
    send_cross_frame(24'h64FF00, 24'h6400FF, 1'b0);
    send_cross_frame(24'hFF00FF, 24'hFFFF00, 1'b1);

    // Wider rows in full, then a register value past the maximum that clamps,
    // cut short before any result is due.
    set_frame(40, 4, 1'b1);
    send_frame(40, 4, 0);
    set_frame(4095, 1, 1'b0);
    send_frame(lsh_pkg::MaxWidth, 1, 24);

    // Random part: mostly small well-formed frames, some cut short before a restart.
    bulk_base = sent;
    in_bulk   = 1'b1;
    phase     = 0;
    while (sent < bulk_base + BulkItems) begin
      case (phase)
        2: begin
          // zero width and height act as a 1x1 frame
          set_frame(0, 0, 1'($urandom_range(1)));
          send_frame(1, 1, 0);
          send_frame(1, 1, 0);
        end
        5: begin
          // a write past the register list must not restart the frame in flight
          set_frame(4, 3, 1'($urandom_range(1)));
          send_frame(4, 3, 7);
          apb_write(RegUnmapped, $urandom);
          repeat (10) push_item($urandom_range(9) == 0, 24'($urandom));
        end
        8: begin
          // tallest frame, abandoned part way by the next phase's writes
          set_frame(5, 65535, 1'($urandom_range(1)));
          send_frame(5, 65535, 40);
        end
        default: begin
          w      = $urandom_range(1, 12);
          h      = $urandom_range(1, 6);
          frames = $urandom_range(1, 3);
          set_frame(w, h, 1'($urandom_range(1)));
          for (int unsigned f = 1; f <= frames; f++) begin
            if (f == frames && $urandom_range(5) == 0)
              send_frame(w, h, $urandom_range(1, w * h + w));
            else send_frame(w, h, 0);
          end
        end
      endcase
      phase++;
    end
    steady = 1'b0;

    settle();
    if (board.mismatches == 0 && board.owed_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
